// File: hdl/lfrt_pkg.sv
`timescale 1ns / 1ps
// lfrt_pkg: result kinds, register indexes and sequencer state codes
// for the lru frame residency tracker; no dependencies
package lfrt_pkg;

	localparam int KIND_W = 2;
	localparam int ID_W   = 6;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 2;
	localparam int MIN_LIMIT = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_EVICT = 2'd0,
		KIND_HIT   = 2'd1,
		KIND_LOAD  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ON_DEMAND      = 2'd0,
		REG_NUM_FRAMES     = 2'd1,
		REG_RESIDENT_LIMIT = 2'd2,
		REG_NONE           = 2'd3
	} reg_idx_t;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_CLR    = 11'b00000000010,
		ST_CHECK  = 11'b00000000100,
		ST_HIT    = 11'b00000001000,
		ST_EVAL   = 11'b00000010000,
		ST_SCAN   = 11'b00000100000,
		ST_DRAIN  = 11'b00001000000,
		ST_VICT   = 11'b00010000000,
		ST_LOAD   = 11'b00100000000,
		ST_CHKALL = 11'b01000000000,
		ST_EMLOAD = 11'b10000000000
	} state_t;

endpackage

// File: hdl/lfrt_ram.sv
`timescale 1ns / 1ps
// lfrt_ram: generic single write port, single read port ram with registered read
// no dependencies
module lfrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/lfrt_min_unit.sv
`timescale 1ns / 1ps
// lfrt_min_unit: shared tick comparator, keeps the oldest candidate seen in a sweep
// no dependencies; the earlier candidate wins on equal ticks
module lfrt_min_unit #(
	parameter int IDXW  = 7,
	parameter int TICKW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             cand_valid,
	input  logic [IDXW-1:0]  cand_idx,
	input  logic [TICKW-1:0] cand_tick,
	output logic             found,
	output logic [IDXW-1:0]  best_idx
);

	logic             found_q;
	logic [IDXW-1:0]  best_idx_q;
	logic [TICKW-1:0] best_tick_q;
	logic             take;

	assign take = cand_valid && (!found_q || (cand_tick < best_tick_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && take) begin
			best_idx_q  <= cand_idx;
			best_tick_q <= cand_tick;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;

endmodule

// File: hdl/lru_frame_residency_tracker_top.sv
`timescale 1ns / 1ps
// lru_frame_residency_tracker_top: sequencer, residency flags, tick ram and result register
// depends on lfrt_pkg, lfrt_ram and lfrt_min_unit
//
// Tracks which frames are resident and answers each in-range access beat with a hit,
// or with zero or more evictions followed by a load; an access beyond the effective
// frame count gets no result, and a clear beat answers with one clear-done result.
// Items are handled one at a time and in_ready is high only while the sequencer is
// idle. A miss runs the all-resident check over the nf effective frames, where nf is
// the effective frame count; in on-demand mode every eviction search sweeps the tick
// ram one entry per cycle through a single tick comparator. A result that waits for
// out_ready holds the sequencer in its state. Results wait in an output register,
// so a new beat can be taken while the last result is still pending.
module lru_frame_residency_tracker_top #(
	parameter int NFRAMES   = 64,
	parameter int TICK_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [5:0]                frame_index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [lfrt_pkg::KIND_W-1:0] kind,
	output logic [lfrt_pkg::ID_W-1:0] frame_id,
	output logic                      release_reader,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lfrt_pkg::IDX_W-1:0] cfg_index,
	input  logic [lfrt_pkg::CFG_W-1:0] cfg_data
);

	import lfrt_pkg::*;

	localparam int IW = $clog2(NFRAMES);
	localparam int CW = $clog2(NFRAMES + 1);
	localparam int NW = (CW > CFG_W) ? CW : CFG_W;

	state_t state_q;

	logic             on_demand_q;
	logic [CFG_W-1:0] num_frames_q;
	logic [CFG_W-1:0] resident_limit_q;

	logic [NFRAMES-1:0]   resident_q;
	logic [NFRAMES-1:0]   tick_vld_q;
	logic [TICK_BITS-1:0] use_tick_q;
	logic [TICK_BITS-1:0] tick_nx;
	logic [NW-1:0]        count_q;
	logic [NW-1:0]        cnt_q;
	logic [NW-1:0]        cnt_nx;
	logic [IW-1:0]        cnt_i;
	logic                 all_q;

	logic          op_q;
	logic [NW-1:0] f_q;
	logic [IW-1:0] f_i;

	logic [NW-1:0] nf;
	logic [NW-1:0] lim;
	logic          f_ok;

	logic                 act_s1;
	logic                 cand_v_s1;
	logic                 tv_s1;
	logic [NW-1:0]        idx_s1;
	logic [TICK_BITS-1:0] rdata;
	logic                 ram_we;

	logic          found;
	logic [NW-1:0] best_idx;
	logic [IW-1:0] best_i;

	logic          out_valid_q;
	kind_t         kind_q;
	logic [ID_W-1:0] frame_id_q;
	logic          release_q;
	logic          last_q;
	logic          out_free;

	logic          emit_en;
	kind_t         emit_kind;
	logic [NW-1:0] emit_id;
	logic          emit_rel;
	logic          emit_last;

	// effective frame count and limit
	always_comb begin
		if (num_frames_q == '0) begin
			nf = NW'(1);
		end else if (NW'(num_frames_q) > NW'(NFRAMES)) begin
			nf = NW'(NFRAMES);
		end else begin
			nf = NW'(num_frames_q);
		end
		if (resident_limit_q < CFG_W'(MIN_LIMIT)) begin
			lim = NW'(MIN_LIMIT);
		end else begin
			lim = NW'(resident_limit_q);
		end
	end

	assign f_ok     = f_q < nf;
	assign f_i      = f_q[IW-1:0];
	assign cnt_i    = cnt_q[IW-1:0];
	assign cnt_nx   = cnt_q + 1'b1;
	assign best_i   = best_idx[IW-1:0];
	assign tick_nx  = (&use_tick_q) ? use_tick_q : use_tick_q + 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign ram_we   = (state_q == ST_CHECK) && f_ok && on_demand_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	lfrt_ram #(
		.WIDTH(TICK_BITS),
		.DEPTH(NFRAMES)
	) u_tick_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (f_i),
		.wdata (tick_nx),
		.raddr (cnt_i),
		.rdata (rdata)
	);

	lfrt_min_unit #(
		.IDXW (NW),
		.TICKW(TICK_BITS)
	) u_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (state_q == ST_EVAL),
		.cand_valid(act_s1 && cand_v_s1),
		.cand_idx  (idx_s1),
		.cand_tick (tv_s1 ? rdata : '0),
		.found     (found),
		.best_idx  (best_idx)
	);

	always_comb begin
		emit_en   = 1'b0;
		emit_kind = KIND_HIT;
		emit_id   = f_q;
		emit_rel  = 1'b0;
		emit_last = 1'b1;
		case (state_q)
			ST_CLR: begin
				emit_en   = out_free;
				emit_kind = KIND_CLEAR;
				emit_id   = '0;
			end
			ST_HIT: begin
				emit_en = out_free;
			end
			ST_VICT: begin
				emit_en   = found && out_free;
				emit_kind = KIND_EVICT;
				emit_id   = best_idx;
				emit_last = 1'b0;
			end
			ST_EMLOAD: begin
				emit_en   = out_free;
				emit_kind = KIND_LOAD;
				emit_rel  = all_q && (!on_demand_q || (lim >= nf));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			on_demand_q      <= 1'b0;
			num_frames_q     <= CFG_W'(64);
			resident_limit_q <= CFG_W'(64);
			resident_q       <= '0;
			tick_vld_q       <= '0;
			use_tick_q       <= '0;
			count_q          <= '0;
			cnt_q            <= '0;
			all_q            <= 1'b0;
			act_s1           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_ON_DEMAND:      on_demand_q      <= cfg_data[0];
					REG_NUM_FRAMES:     num_frames_q     <= cfg_data;
					REG_RESIDENT_LIMIT: resident_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			act_s1 <= (state_q == ST_SCAN);

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (op) begin
							resident_q <= '0;
							tick_vld_q <= '0;
							use_tick_q <= '0;
							count_q    <= '0;
							state_q    <= ST_CLR;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CLR, ST_HIT, ST_EMLOAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (!f_ok) begin
						state_q <= ST_IDLE;
					end else begin
						if (on_demand_q) begin
							use_tick_q      <= tick_nx;
							tick_vld_q[f_i] <= 1'b1;
						end
						if (resident_q[f_i]) begin
							state_q <= ST_HIT;
						end else if (on_demand_q) begin
							state_q <= ST_EVAL;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EVAL: begin
					cnt_q <= '0;
					if (count_q >= lim) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_nx;
					if (cnt_nx == nf) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_VICT;
				end
				ST_VICT: begin
					if (!found) begin
						state_q <= ST_LOAD;
					end else if (out_free) begin
						resident_q[best_i] <= 1'b0;
						count_q            <= count_q - 1'b1;
						state_q            <= ST_EVAL;
					end
				end
				ST_LOAD: begin
					resident_q[f_i] <= 1'b1;
					count_q         <= count_q + 1'b1;
					cnt_q           <= '0;
					all_q           <= 1'b1;
					state_q         <= ST_CHKALL;
				end
				ST_CHKALL: begin
					if (!resident_q[cnt_i]) begin
						all_q <= 1'b0;
					end
					cnt_q <= cnt_nx;
					if (cnt_nx == nf) begin
						state_q <= ST_EMLOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op;
			f_q  <= NW'(frame_index);
		end
		cand_v_s1 <= resident_q[cnt_i] && (cnt_q != f_q);
		tv_s1     <= tick_vld_q[cnt_i];
		idx_s1    <= cnt_q;
		if (emit_en) begin
			kind_q     <= emit_kind;
			frame_id_q <= emit_id[ID_W-1:0];
			release_q  <= emit_rel;
			last_q     <= emit_last || op_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign frame_id       = frame_id_q;
	assign release_reader = release_q;
	assign last           = last_q;

endmodule

// File: test/lfrt_tb_pkg.sv
`timescale 1ns / 1ps
// lfrt_tb_pkg: request op codes shared by the tracker bench and its checker
// no dependencies
package lfrt_tb_pkg;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

endpackage

// File: test/lfrt_checker.sv
`timescale 1ns / 1ps
// lfrt_checker: follows request, register and result beats of the tracker, keeps its own
// residency and tick state and compares every result beat; depends on lfrt_pkg, lfrt_tb_pkg
module lfrt_checker #(
	parameter int NFRAMES   = 64,
	parameter int TICK_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          op,
	input  logic [5:0]                    frame_index,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [lfrt_pkg::KIND_W-1:0]   kind,
	input  logic [lfrt_pkg::ID_W-1:0]     frame_id,
	input  logic                          release_reader,
	input  logic                          last,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [lfrt_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lfrt_pkg::CFG_W-1:0]    cfg_data,
	output int                            mismatches,
	output int                            outstanding
);
	import lfrt_pkg::*;
	import lfrt_tb_pkg::*;

	typedef struct packed {
		kind_t            kind;
		logic [ID_W-1:0]  frame;
		logic             rel;
		logic             last;
	} answer_t;

	answer_t              answers_due[$];
	logic                 occupied [NFRAMES];
	logic [TICK_BITS-1:0] stamp [NFRAMES];
	logic [TICK_BITS-1:0] tick_now;
	int unsigned          occupancy;
	logic                 od_reg;
	logic [CFG_W-1:0]     nf_reg;
	logic [CFG_W-1:0]     lim_reg;
	answer_t              seen;
	answer_t              due;

	function automatic void queue_answer(input answer_t a);
		answers_due.insert(answers_due.size(), a);
	endfunction

	task automatic track_request(input op_t o, input logic [ID_W-1:0] f);
		int unsigned nf;
		int unsigned lim;
		int          victim;
		logic        all_in;
		nf  = (nf_reg == 0) ? 1 : ((nf_reg > NFRAMES) ? NFRAMES : nf_reg);
		lim = (lim_reg < MIN_LIMIT) ? MIN_LIMIT : lim_reg;
		if (o == OP_CLEAR) begin
			for (int i = 0; i < NFRAMES; i++) begin
				occupied[i] = 1'b0;
				stamp[i]    = '0;
			end
			tick_now  = '0;
			occupancy = 0;
			queue_answer(answer_t'{KIND_CLEAR, '0, 1'b0, 1'b1});
			return;
		end
		// out of range access: no result
		if (f >= nf)
			return;
		if (od_reg) begin
			if (tick_now != {TICK_BITS{1'b1}})
				tick_now = tick_now + 1'b1;
			stamp[f] = tick_now;
		end
		if (occupied[f]) begin
			queue_answer(answer_t'{KIND_HIT, f, 1'b0, 1'b1});
			return;
		end
		if (od_reg) begin
			while (occupancy >= lim) begin
				victim = -1;
				for (int i = 0; i < nf; i++)
					if (i != f && occupied[i] && (victim < 0 || stamp[i] < stamp[victim]))
						victim = i;
				if (victim < 0)
					break;
				occupied[victim] = 1'b0;
				occupancy--;
				queue_answer(answer_t'{KIND_EVICT, ID_W'(victim), 1'b0, 1'b0});
			end
		end
		occupied[f] = 1'b1;
		occupancy++;
		all_in = 1'b1;
		for (int i = 0; i < nf; i++)
			if (!occupied[i])
				all_in = 1'b0;
		queue_answer(answer_t'{KIND_LOAD, f, all_in && (!od_reg || lim >= nf), 1'b1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answers_due.delete();
			for (int i = 0; i < NFRAMES; i++) begin
				occupied[i] = 1'b0;
				stamp[i]    = '0;
			end
			tick_now    = '0;
			occupancy   = 0;
			od_reg      = 1'b0;
			nf_reg      = CFG_W'(NFRAMES);
			lim_reg     = CFG_W'(NFRAMES);
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = answer_t'{kind_t'(kind), frame_id, release_reader, last};
				if (answers_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: kind %0d frame %0d rel %0b last %0b",
							seen.kind, seen.frame, seen.rel, seen.last);
					mismatches++;
				end else begin
					due = answers_due.pop_front();
					if (seen.kind !== due.kind || seen.frame !== due.frame ||
							seen.rel !== due.rel || seen.last !== due.last) begin
						if (mismatches < 10) begin
							$display("result mismatch: expected kind %0d frame %0d rel %0b last %0b",
								due.kind, due.frame, due.rel, due.last);
							$display("  got kind %0d frame %0d rel %0b last %0b",
								seen.kind, seen.frame, seen.rel, seen.last);
						end
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ON_DEMAND:      od_reg  = cfg_data[0];
					REG_NUM_FRAMES:     nf_reg  = cfg_data;
					REG_RESIDENT_LIMIT: lim_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				track_request(op_t'(op), frame_index);
			outstanding = answers_due.size();
		end
	end

endmodule

// File: test/lru_frame_residency_tracker_top_tb.sv
`timescale 1ns / 1ps
// lru_frame_residency_tracker_top_tb: clock, reset, request and register stimulus, result
// back-pressure, watchdog and verdict; depends on lfrt_pkg, lfrt_tb_pkg and lfrt_checker
module lru_frame_residency_tracker_top_tb;
	import lfrt_pkg::*;
	import lfrt_tb_pkg::*;

	localparam int NFRAMES       = 64;
	localparam int RANDOM_ITEMS  = 420;
	localparam int MAX_GAP       = 18;
	localparam int SETTLE_CYCLES = 160;
	localparam int LONG_HOLD     = 300;
	localparam int QUIET_LIMIT   = 4000;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic                op             = OP_ACCESS;
	logic [5:0]          frame_index    = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [ID_W-1:0]     frame_id;
	logic                release_reader;
	logic                last;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index      = REG_ON_DEMAND;
	logic [CFG_W-1:0]    cfg_data       = '0;

	int                  mismatches;
	int                  outstanding;
	int unsigned         quiet          = 0;
	int unsigned         random_count   = 0;
	bit                  tx_busy        = 1'b0;
	bit                  rx_busy        = 1'b0;
	bit                  long_hold_req  = 1'b0;

	lru_frame_residency_tracker_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.frame_index    (frame_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.frame_id       (frame_id),
		.release_reader (release_reader),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	lfrt_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.frame_index    (frame_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.frame_id       (frame_id),
		.release_reader (release_reader),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int unsigned draw_gap(input bit busy);
		return busy ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic send_item(input op_t o, input int unsigned f);
		int unsigned w;
		w = draw_gap(tx_busy);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= o;
		frame_index <= f[5:0];
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[CFG_W-1:0];
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// wait for every result, then give an ignored access time to finish
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input bit od, input int unsigned nf, input int unsigned lim);
		settle();
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, $urandom_range(0, 127));
		write_reg(REG_ON_DEMAND, od);
		write_reg(REG_NUM_FRAMES, nf);
		write_reg(REG_RESIDENT_LIMIT, lim);
		cfg_valid <= 1'b0;
	endtask

	// touch frames 0..count-1 once each in shuffled order, leaving one out
	task automatic sweep(input int unsigned count, input int unsigned skip);
		int unsigned order [NFRAMES];
		int unsigned j;
		int unsigned t;
		for (int i = 0; i < count; i++)
			order[i] = i;
		for (int i = count - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < count; i++) begin
			if (order[i] != skip) begin
				send_item(OP_ACCESS, order[i]);
				random_count++;
			end
		end
	endtask

	// fill all but one frame, drop the limit, then miss on the missing one
	task automatic squeeze_phase();
		int unsigned nf;
		int unsigned skip;
		nf   = $urandom_range(0, 1) ? NFRAMES : $urandom_range(NFRAMES + 1, 127);
		skip = $urandom_range(0, NFRAMES - 1);
		set_config($urandom_range(0, 1), nf, $urandom_range(NFRAMES, 127));
		send_item(OP_CLEAR, $urandom_range(0, 63));
		sweep(NFRAMES, skip);
		set_config(1'b1, nf, $urandom_range(0, 2));
		send_item(OP_ACCESS, skip);
		random_count += 2;
	endtask

	// residents beyond a shrunk frame count stay counted but are never victims
	task automatic shrink_phase();
		int unsigned skip;
		skip = $urandom_range(0, 3);
		set_config(1'b1, 16, NFRAMES);
		send_item(OP_CLEAR, $urandom_range(0, 63));
		sweep(16, skip);
		set_config(1'b1, 4, $urandom_range(2, 8));
		send_item(OP_ACCESS, skip);
		random_count += 2;
		repeat (8) begin
			send_item(OP_ACCESS, $urandom_range(0, 5));
			random_count++;
		end
	endtask

	task automatic mixed_phase();
		int unsigned nf;
		int unsigned lim;
		int unsigned nf_eff;
		int unsigned hot;
		int unsigned n;
		int unsigned r;
		case ($urandom_range(0, 7))
			0: nf = 1;
			1: nf = 2;
			2: nf = NFRAMES;
			3: nf = 0;
			4: nf = $urandom_range(NFRAMES + 1, 127);
			default: nf = $urandom_range(3, 24);
		endcase
		nf_eff = (nf == 0) ? 1 : ((nf > NFRAMES) ? NFRAMES : nf);
		case ($urandom_range(0, 7))
			0: lim = 2;
			1: lim = $urandom_range(0, 1);
			2: lim = NFRAMES;
			3: lim = $urandom_range(NFRAMES + 1, 127);
			default: lim = $urandom_range(2, (nf_eff > 2) ? nf_eff : 2);
		endcase
		hot = (lim + 1 < nf_eff) ? lim + 1 : nf_eff;
		set_config($urandom_range(0, 3) != 0, nf, lim);
		tx_busy = ($urandom_range(0, 3) == 0);
		n = $urandom_range(15, 40);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_item(OP_CLEAR, $urandom_range(0, 63));
				random_count++;
			end else if (r < 10 && nf_eff < NFRAMES) begin
				send_item(OP_ACCESS, $urandom_range(nf_eff, 63));
			end else begin
				send_item(OP_ACCESS, (r < 55) ? $urandom_range(0, hot - 1) :
					$urandom_range(0, nf_eff - 1));
				random_count++;
			end
		end
	endtask

	// result side: random stalls, fast stretches and one long hold-off
	initial begin
		int unsigned w;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_busy = !rx_busy;
			w = long_hold_req ? LONG_HOLD : draw_gap(rx_busy);
			long_hold_req = 1'b0;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// eager mode at reset settings
		send_item(OP_ACCESS, 0);
		send_item(OP_ACCESS, 0);
		send_item(OP_ACCESS, 63);
		send_item(OP_ACCESS, 42);
		send_item(OP_ACCESS, 21);
		send_item(OP_CLEAR, 63);

		// on-demand with the smallest limit and an ignored frame
		set_config(1'b1, 4, 2);
		send_item(OP_ACCESS, 0);
		send_item(OP_ACCESS, 1);
		send_item(OP_ACCESS, 2);
		send_item(OP_ACCESS, 1);
		send_item(OP_ACCESS, 3);
		send_item(OP_ACCESS, 0);
		send_item(OP_ACCESS, 7);
		send_item(OP_CLEAR, 0);

		// zero frame count and limit below two
		set_config(1'b1, 0, 0);
		send_item(OP_ACCESS, 0);
		send_item(OP_ACCESS, 1);
		send_item(OP_ACCESS, 0);

		// eager mode fills a small block
		set_config(1'b0, 2, 1);
		send_item(OP_ACCESS, 0);
		send_item(OP_ACCESS, 1);
		send_item(OP_ACCESS, 1);
		send_item(OP_CLEAR, 42);

		// register values above range
		set_config(1'b1, 127, 127);
		send_item(OP_ACCESS, 63);
		send_item(OP_ACCESS, 5);
		send_item(OP_CLEAR, 21);

		long_hold_req = 1'b1;
		tx_busy       = 1'b1;
		squeeze_phase();
		tx_busy       = 1'b0;
		shrink_phase();
		while (random_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: squeeze_phase();
				1: shrink_phase();
				default: mixed_phase();
			endcase
		end
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
hdl/lfrt_pkg.sv
hdl/lfrt_ram.sv
hdl/lfrt_min_unit.sv
hdl/lru_frame_residency_tracker_top.sv
test/lfrt_tb_pkg.sv
test/lfrt_checker.sv
test/lru_frame_residency_tracker_top_tb.sv
